// ----- sv/tuv_pkg.sv -----
// ----------------------------------------------------------------------------
// tuv_pkg
// Shared types, widths and codes for the triangle tangent pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tuv_pkg;

    // fixed-point format and derived widths
    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;              // coordinate width
    localparam int TW        = 16;              // tolerance width
    localparam int DW        = CW + 1;          // difference width
    localparam int PW        = 2 * DW;          // product width
    localparam int NW        = PW + 1;          // numerator / determinant width
    localparam int QB        = CW + 1;          // quotient bits produced
    localparam int NSW       = NW + FRAC_BITS;  // scaled dividend width
    localparam int RW        = NW + 1;          // partial remainder width

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SHORT_EDGE = 2'd1,
        ST_NO_UV      = 2'd2,
        ST_DET_ZERO   = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [CW-1:0] corner_x;
        logic signed [CW-1:0] corner_y;
        logic signed [CW-1:0] corner_z;
        logic signed [CW-1:0] next_x;
        logic signed [CW-1:0] next_y;
        logic signed [CW-1:0] next_z;
        logic signed [CW-1:0] prev_x;
        logic signed [CW-1:0] prev_y;
        logic signed [CW-1:0] prev_z;
        logic [2*CW-1:0]      corner_uv;
        logic [2*CW-1:0]      next_uv;
        logic [2*CW-1:0]      prev_uv;
    } in_item_t;

    typedef struct packed {
        logic signed [CW-1:0] tangent_x;
        logic signed [CW-1:0] tangent_y;
        logic signed [CW-1:0] tangent_z;
        logic [1:0]           status;
        logic                 saturated;
    } out_item_t;

    // divide request from the front end
    typedef struct packed {
        logic [2:0][NW-1:0] num;
        logic [NW-1:0]      den;
        status_t            status;
    } div_req_t;

    // raw quotients from the divider
    typedef struct packed {
        logic [2:0][QB-1:0] quo;
        logic [2:0]         ovf;
        logic [2:0]         neg;
        status_t            status;
    } div_res_t;

endpackage

// ----- sv/tuv_front.sv -----
// ----------------------------------------------------------------------------
// tuv_front
// Four-stage front end: edge deltas, products and zero tests, determinant
// and numerators, degenerate checks and divide operand selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tuv_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tuv_pkg::in_item_t   in_data,
    input  logic [tuv_pkg::TW-1:0]   tol,
    input  logic [2*tuv_pkg::TW-1:0] tol_sq,
    output logic                out_valid,
    input  logic                out_stall,
    output tuv_pkg::div_req_t   out_req
);

    localparam int SUMW = 2 * tuv_pkg::TW + 2;

    // sign-extended difference a - b
    function automatic logic [tuv_pkg::DW-1:0] sdiff(
        input logic [tuv_pkg::CW-1:0] a,
        input logic [tuv_pkg::CW-1:0] b
    );
        sdiff = {a[tuv_pkg::CW-1], a} - {b[tuv_pkg::CW-1], b};
    endfunction

    // magnitude of a difference
    function automatic logic [tuv_pkg::DW-1:0] mag_dw(input logic [tuv_pkg::DW-1:0] v);
        mag_dw = v[tuv_pkg::DW-1] ? (~v + 1'b1) : v;
    endfunction

    // stage valids and load enables
    logic [3:0] v_reg;
    logic [3:0] ld;

    always_comb
    begin
        ld[3] = !v_reg[3] || !out_stall;
        ld[2] = !v_reg[2] || ld[3];
        ld[1] = !v_reg[1] || ld[2];
        ld[0] = !v_reg[0] || ld[1];
    end

    assign in_stall  = !ld[0];
    assign out_valid = v_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0]) v_reg[0] <= in_valid;
            if (ld[1]) v_reg[1] <= v_reg[0];
            if (ld[2]) v_reg[2] <= v_reg[1];
            if (ld[3]) v_reg[3] <= v_reg[2];
        end
    end

    // input vertices as arrays
    logic [tuv_pkg::CW-1:0] pc [3];
    logic [tuv_pkg::CW-1:0] pn [3];
    logic [tuv_pkg::CW-1:0] pp [3];

    always_comb
    begin
        pc[0] = in_data.corner_x;
        pc[1] = in_data.corner_y;
        pc[2] = in_data.corner_z;
        pn[0] = in_data.next_x;
        pn[1] = in_data.next_y;
        pn[2] = in_data.next_z;
        pp[0] = in_data.prev_x;
        pp[1] = in_data.prev_y;
        pp[2] = in_data.prev_z;
    end

    // stage 1: edge and texture deltas
    logic [tuv_pkg::DW-1:0] s1_p1_reg [3];
    logic [tuv_pkg::DW-1:0] s1_p2_reg [3];
    logic [tuv_pkg::DW-1:0] s1_du1_reg, s1_dv1_reg, s1_du2_reg, s1_dv2_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_p1_reg[i] <= sdiff(pn[i], pc[i]);
                s1_p2_reg[i] <= sdiff(pp[i], pc[i]);
            end
            s1_du1_reg <= sdiff(in_data.next_uv[2*tuv_pkg::CW-1:tuv_pkg::CW],
                                in_data.corner_uv[2*tuv_pkg::CW-1:tuv_pkg::CW]);
            s1_dv1_reg <= sdiff(in_data.next_uv[tuv_pkg::CW-1:0],
                                in_data.corner_uv[tuv_pkg::CW-1:0]);
            s1_du2_reg <= sdiff(in_data.prev_uv[2*tuv_pkg::CW-1:tuv_pkg::CW],
                                in_data.corner_uv[2*tuv_pkg::CW-1:tuv_pkg::CW]);
            s1_dv2_reg <= sdiff(in_data.prev_uv[tuv_pkg::CW-1:0],
                                in_data.corner_uv[tuv_pkg::CW-1:0]);
        end
    end

    // stage 2: magnitudes, squares and cross products
    logic [tuv_pkg::DW-1:0] m1 [3];
    logic [tuv_pkg::DW-1:0] m2 [3];
    logic [tuv_pkg::DW-1:0] mdu1, mdv1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m1[i] = mag_dw(s1_p1_reg[i]);
            m2[i] = mag_dw(s1_p2_reg[i]);
        end
        mdu1 = mag_dw(s1_du1_reg);
        mdv1 = mag_dw(s1_dv1_reg);
    end

    logic [2:0]               s2_lt1_reg, s2_lt2_reg;
    logic [2*tuv_pkg::TW-1:0] s2_sq1_reg [3];
    logic [2*tuv_pkg::TW-1:0] s2_sq2_reg [3];
    logic                     s2_z1_reg, s2_z2_reg;
    logic                     s2_du1_small_reg, s2_dv1_small_reg;
    logic signed [tuv_pkg::PW-1:0] s2_pa_reg, s2_pb_reg;
    logic signed [tuv_pkg::PW-1:0] s2_pc_reg [3];
    logic signed [tuv_pkg::PW-1:0] s2_pd_reg [3];
    logic [tuv_pkg::DW-1:0]   s2_p1_reg [3];
    logic [tuv_pkg::DW-1:0]   s2_du1_reg;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_lt1_reg[i] <= m1[i] < tuv_pkg::DW'(tol);
                s2_lt2_reg[i] <= m2[i] < tuv_pkg::DW'(tol);
                s2_sq1_reg[i] <= m1[i][tuv_pkg::TW-1:0] * m1[i][tuv_pkg::TW-1:0];
                s2_sq2_reg[i] <= m2[i][tuv_pkg::TW-1:0] * m2[i][tuv_pkg::TW-1:0];
                s2_pc_reg[i]  <= $signed(s1_dv1_reg) * $signed(s1_p2_reg[i]);
                s2_pd_reg[i]  <= $signed(s1_dv2_reg) * $signed(s1_p1_reg[i]);
                s2_p1_reg[i]  <= s1_p1_reg[i];
            end
            s2_z1_reg <= (s1_p1_reg[0] == '0) && (s1_p1_reg[1] == '0) && (s1_p1_reg[2] == '0);
            s2_z2_reg <= (s1_p2_reg[0] == '0) && (s1_p2_reg[1] == '0) && (s1_p2_reg[2] == '0);
            s2_du1_small_reg <= (s1_du1_reg == '0) || (mdu1 < tuv_pkg::DW'(tol));
            s2_dv1_small_reg <= (s1_dv1_reg == '0) || (mdv1 < tuv_pkg::DW'(tol));
            s2_pa_reg  <= $signed(s1_dv1_reg) * $signed(s1_du2_reg);
            s2_pb_reg  <= $signed(s1_dv2_reg) * $signed(s1_du1_reg);
            s2_du1_reg <= s1_du1_reg;
        end
    end

    // stage 3: squared edge lengths, determinant and numerators
    logic [SUMW-1:0] sum1, sum2;

    always_comb
    begin
        sum1 = SUMW'(s2_sq1_reg[0]) + SUMW'(s2_sq1_reg[1]) + SUMW'(s2_sq1_reg[2]);
        sum2 = SUMW'(s2_sq2_reg[0]) + SUMW'(s2_sq2_reg[1]) + SUMW'(s2_sq2_reg[2]);
    end

    logic                   s3_short_reg;
    logic                   s3_du1_small_reg, s3_dv1_small_reg;
    logic [tuv_pkg::NW-1:0] s3_det_reg;
    logic [tuv_pkg::NW-1:0] s3_num_reg [3];
    logic [tuv_pkg::DW-1:0] s3_p1_reg [3];
    logic [tuv_pkg::DW-1:0] s3_du1_reg;

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            s3_short_reg <= s2_z1_reg || s2_z2_reg
                         || ((&s2_lt1_reg) && (sum1 < SUMW'(tol_sq)))
                         || ((&s2_lt2_reg) && (sum2 < SUMW'(tol_sq)));
            s3_det_reg <= {s2_pa_reg[tuv_pkg::PW-1], s2_pa_reg}
                        - {s2_pb_reg[tuv_pkg::PW-1], s2_pb_reg};
            for (int i = 0; i < 3; i++)
            begin
                s3_num_reg[i] <= {s2_pc_reg[i][tuv_pkg::PW-1], s2_pc_reg[i]}
                               - {s2_pd_reg[i][tuv_pkg::PW-1], s2_pd_reg[i]};
                s3_p1_reg[i]  <= s2_p1_reg[i];
            end
            s3_du1_small_reg <= s2_du1_small_reg;
            s3_dv1_small_reg <= s2_dv1_small_reg;
            s3_du1_reg       <= s2_du1_reg;
        end
    end

    // stage 4: degenerate checks and divide operand selection
    logic [tuv_pkg::NW-1:0] lim;
    logic                   det_small;
    tuv_pkg::div_req_t      req_next;
    tuv_pkg::div_req_t      req_reg;

    always_comb
    begin
        lim = tuv_pkg::NW'({tol, {tuv_pkg::FRAC_BITS{1'b0}}});
        det_small = (s3_det_reg == '0)
                 || (s3_det_reg[tuv_pkg::NW-1] ? ((~s3_det_reg + 1'b1) < lim)
                                                : (s3_det_reg < lim));
        for (int i = 0; i < 3; i++)
        begin
            req_next.num[i] = s3_num_reg[i];
        end
        req_next.den    = s3_det_reg;
        req_next.status = tuv_pkg::ST_OK;
        if (s3_short_reg)
        begin
            req_next.status = tuv_pkg::ST_SHORT_EDGE;
        end
        else if (s3_dv1_small_reg)
        begin
            // v flat along the first edge: tangent is dP1 / du1
            if (s3_du1_small_reg)
            begin
                req_next.status = tuv_pkg::ST_NO_UV;
            end
            for (int i = 0; i < 3; i++)
            begin
                req_next.num[i] = {{(tuv_pkg::NW-tuv_pkg::DW){s3_p1_reg[i][tuv_pkg::DW-1]}},
                                   s3_p1_reg[i]};
            end
            req_next.den = {{(tuv_pkg::NW-tuv_pkg::DW){s3_du1_reg[tuv_pkg::DW-1]}}, s3_du1_reg};
        end
        else if (det_small)
        begin
            req_next.status = tuv_pkg::ST_DET_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            req_reg <= req_next;
        end
    end

    assign out_req = req_reg;

endmodule

// ----- sv/tuv_div.sv -----
// ----------------------------------------------------------------------------
// tuv_div
// Pipelined restoring divider for the three tangent lanes sharing one
// divisor: sign split, overflow test, then one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tuv_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  tuv_pkg::div_req_t in_req,
    output logic              out_valid,
    input  logic              out_stall,
    output tuv_pkg::div_res_t out_res
);

    localparam int NS = tuv_pkg::QB + 2;   // sign stage, overflow stage, bit stages
    localparam int HW = tuv_pkg::NSW - tuv_pkg::QB;

    // stage valids and load enables
    logic [NS-1:0] v_reg;
    logic [NS-1:0] ld;

    always_comb
    begin
        ld[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign in_stall  = !ld[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (ld[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // sign split: magnitudes and quotient sign
    logic [tuv_pkg::NW-1:0] nmag [3];
    logic [tuv_pkg::NW-1:0] dmag;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nmag[i] = in_req.num[i][tuv_pkg::NW-1] ? (~in_req.num[i] + 1'b1) : in_req.num[i];
        end
        dmag = in_req.den[tuv_pkg::NW-1] ? (~in_req.den + 1'b1) : in_req.den;
    end

    logic [tuv_pkg::NSW-1:0] sa_n_reg [3];
    logic [tuv_pkg::NW-1:0]  sa_d_reg;
    logic [2:0]              sa_neg_reg;
    tuv_pkg::status_t        sa_status_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sa_n_reg[i]   <= {nmag[i], {tuv_pkg::FRAC_BITS{1'b0}}};
                sa_neg_reg[i] <= in_req.num[i][tuv_pkg::NW-1] ^ in_req.den[tuv_pkg::NW-1];
            end
            sa_d_reg      <= dmag;
            sa_status_reg <= in_req.status;
        end
    end

    // bit stages: index 0 holds the overflow test, index j the j-th quotient bit
    logic [tuv_pkg::RW-1:0] st_rem_reg [tuv_pkg::QB+1][3];
    logic [tuv_pkg::QB-1:0] st_nlo_reg [tuv_pkg::QB+1][3];
    logic [tuv_pkg::QB-1:0] st_q_reg   [tuv_pkg::QB+1][3];
    logic [tuv_pkg::NW-1:0] st_d_reg   [tuv_pkg::QB+1];
    logic [2:0]             st_ovf_reg [tuv_pkg::QB+1];
    logic [2:0]             st_neg_reg [tuv_pkg::QB+1];
    tuv_pkg::status_t       st_status_reg [tuv_pkg::QB+1];

    // overflow when the high part of the dividend already reaches the divisor
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                st_rem_reg[0][i] <= tuv_pkg::RW'(sa_n_reg[i][tuv_pkg::NSW-1:tuv_pkg::QB]);
                st_nlo_reg[0][i] <= sa_n_reg[i][tuv_pkg::QB-1:0];
                st_q_reg[0][i]   <= '0;
                st_ovf_reg[0][i] <= tuv_pkg::NW'(sa_n_reg[i][tuv_pkg::NSW-1:tuv_pkg::QB])
                                    >= sa_d_reg;
            end
            st_d_reg[0]      <= sa_d_reg;
            st_neg_reg[0]    <= sa_neg_reg;
            st_status_reg[0] <= sa_status_reg;
        end
    end

    for (genvar j = 1; j <= tuv_pkg::QB; j++)
    begin : g_step
        logic [tuv_pkg::RW-1:0] trial [3];
        logic [2:0]             ge;

        // shift in the next dividend bit and try the subtract
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = {st_rem_reg[j-1][i][tuv_pkg::RW-2:0],
                            st_nlo_reg[j-1][i][tuv_pkg::QB-j]};
                ge[i]    = trial[i] >= tuv_pkg::RW'(st_d_reg[j-1]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[j+1])
            begin
                for (int i = 0; i < 3; i++)
                begin
                    st_rem_reg[j][i] <= ge[i] ? (trial[i] - tuv_pkg::RW'(st_d_reg[j-1]))
                                              : trial[i];
                    st_q_reg[j][i]   <= {st_q_reg[j-1][i][tuv_pkg::QB-2:0], ge[i]};
                    st_nlo_reg[j][i] <= st_nlo_reg[j-1][i];
                end
                st_d_reg[j]      <= st_d_reg[j-1];
                st_ovf_reg[j]    <= st_ovf_reg[j-1];
                st_neg_reg[j]    <= st_neg_reg[j-1];
                st_status_reg[j] <= st_status_reg[j-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_res.quo[i] = st_q_reg[tuv_pkg::QB][i];
        end
        out_res.ovf    = st_ovf_reg[tuv_pkg::QB];
        out_res.neg    = st_neg_reg[tuv_pkg::QB];
        out_res.status = st_status_reg[tuv_pkg::QB];
    end

endmodule

// ----- sv/triangle_uv_tangent.sv -----
// ----------------------------------------------------------------------------
// triangle_uv_tangent
// Tangent dP/du at one triangle corner from positions and texture coordinates.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless stalled; divider has 33 bit stages.
// Stalls hold every stage; empty stages keep filling while the output waits.
// Reset: pipeline emptied, the tolerance register returns to 1 (raw Q16.16).
`timescale 1ns / 1ps

module triangle_uv_tangent (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  tuv_pkg::in_item_t        in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output tuv_pkg::out_item_t       out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [tuv_pkg::TW-1:0]   cfg_data
);

    // tolerance register and its square
    logic [tuv_pkg::TW-1:0]   tol_reg;
    logic [2*tuv_pkg::TW-1:0] tol_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= tuv_pkg::TW'(1);
            tol_sq_reg <= (2*tuv_pkg::TW)'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg    <= cfg_data;
            tol_sq_reg <= cfg_data * cfg_data;
        end
    end

    // front end and divider
    logic              fr_valid, fr_stall;
    tuv_pkg::div_req_t fr_req;
    logic              dv_valid, dv_stall;
    tuv_pkg::div_res_t dv_res;

    tuv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .tol       (tol_reg),
        .tol_sq    (tol_sq_reg),
        .out_valid (fr_valid),
        .out_stall (fr_stall),
        .out_req   (fr_req)
    );

    tuv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_stall  (fr_stall),
        .in_req    (fr_req),
        .out_valid (dv_valid),
        .out_stall (dv_stall),
        .out_res   (dv_res)
    );

    // saturation, sign and degenerate gating
    logic [tuv_pkg::QB-1:0] lim [3];
    logic [2:0]             sat;
    logic [tuv_pkg::CW-1:0] mag [3];
    logic [tuv_pkg::CW-1:0] val [3];
    logic                   ok;
    tuv_pkg::out_item_t     out_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lim[i] = {1'b0, dv_res.neg[i], {(tuv_pkg::CW-1){~dv_res.neg[i]}}};
            sat[i] = dv_res.ovf[i] || (dv_res.quo[i] > lim[i]);
            mag[i] = sat[i] ? lim[i][tuv_pkg::CW-1:0] : dv_res.quo[i][tuv_pkg::CW-1:0];
            val[i] = dv_res.neg[i] ? (~mag[i] + 1'b1) : mag[i];
        end
        ok = (dv_res.status == tuv_pkg::ST_OK);
        out_next.tangent_x = ok ? val[0] : '0;
        out_next.tangent_y = ok ? val[1] : '0;
        out_next.tangent_z = ok ? val[2] : '0;
        out_next.status    = dv_res.status;
        out_next.saturated = ok && (|sat);
    end

    // output register
    logic               out_valid_reg;
    tuv_pkg::out_item_t out_data_reg;
    logic               ld_out;

    assign ld_out   = !out_valid_reg || !out_stall;
    assign dv_stall = !ld_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ld_out)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sv/tuv_checker.sv -----
// ----------------------------------------------------------------------------
// tuv_checker
// Port-level checks for the triangle tangent block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tuv_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input tuv_pkg::in_item_t      in_data,
    input logic                   out_valid,
    input logic                   out_stall,
    input tuv_pkg::out_item_t     out_data
);

    // a stalled request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled request changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // a free output never back-pressures the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output free");

    // degenerate results carry zero tangent and no saturation
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != tuv_pkg::ST_OK) |->
            (out_data.tangent_x == '0) && (out_data.tangent_y == '0)
            && (out_data.tangent_z == '0) && !out_data.saturated)
        else $error("degenerate result not cleared");

    // saturation flag implies a clipped component
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            (out_data.tangent_x == 32'h7FFFFFFF) || (out_data.tangent_x == 32'h80000000)
            || (out_data.tangent_y == 32'h7FFFFFFF) || (out_data.tangent_y == 32'h80000000)
            || (out_data.tangent_z == 32'h7FFFFFFF) || (out_data.tangent_z == 32'h80000000))
        else $error("saturated flag without a clipped component");

endmodule

bind triangle_uv_tangent tuv_checker u_tuv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ----- verif/tb_triangle_uv_tangent.sv -----
// ----------------------------------------------------------------------------
// tb_triangle_uv_tangent
// Streams triangle corners through the tangent block and checks every result
// against an exact integer prediction of dP/du, status and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_uv_tangent;

    localparam int LATENCY = 40;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    tuv_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    tuv_pkg::out_item_t out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [tuv_pkg::TW-1:0] cfg_data;

    // shadow copy of the tolerance register
    logic [tuv_pkg::TW-1:0] tol_shadow;
    tuv_pkg::out_item_t     tangent_queue[$];
    int            mismatch_count;
    int            checked_count;
    int            sent_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_cycles;

    triangle_uv_tangent u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // safety limit
    initial
    begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

    // (num << FRAC_BITS) / den truncated toward zero, saturated to 32 bits
    function automatic logic [tuv_pkg::CW-1:0] scaled_quotient(
        input logic signed [127:0] num,
        input logic signed [127:0] den,
        inout logic sat
    );
        logic                neg;
        logic [127:0]        n;
        logic [127:0]        d;
        logic [127:0]        q;
        logic [127:0]        limit;
        neg   = (num < 0) != (den < 0);
        n     = (num < 0) ? -num : num;
        d     = (den < 0) ? -den : den;
        n     = n << tuv_pkg::FRAC_BITS;
        q     = n / d;
        limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > limit)
        begin
            sat = 1'b1;
            q   = limit;
        end
        return neg ? tuv_pkg::CW'(-q) : tuv_pkg::CW'(q);
    endfunction

    function automatic logic edge_is_short(input logic signed [63:0] dx,
                                           input logic signed [63:0] dy,
                                           input logic signed [63:0] dz,
                                           input logic [tuv_pkg::TW-1:0] tol);
        logic [127:0] len2;
        if (dx == 0 && dy == 0 && dz == 0)
            return 1'b1;
        len2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
        return len2 < 128'(64'(tol) * 64'(tol));
    endfunction

    function automatic logic delta_is_small(input logic signed [63:0] d,
                                            input logic [tuv_pkg::TW-1:0] tol);
        logic signed [63:0] m;
        m = (d < 0) ? -d : d;
        return (d == 0) || (m < 64'(tol));
    endfunction

    // expected tangent for one corner
    function automatic tuv_pkg::out_item_t predict_tangent(input tuv_pkg::in_item_t c,
                                                           input logic [tuv_pkg::TW-1:0] tol);
        tuv_pkg::out_item_t r;
        logic signed [63:0] e1[3];
        logic signed [63:0] e2[3];
        logic signed [63:0] u0, v0, du1, dv1, du2, dv2;
        logic signed [127:0] det;
        logic signed [127:0] num;
        logic signed [127:0] absdet;
        logic               sat;
        r   = '0;
        sat = 1'b0;
        e1[0] = 64'(c.next_x) - 64'(c.corner_x);
        e1[1] = 64'(c.next_y) - 64'(c.corner_y);
        e1[2] = 64'(c.next_z) - 64'(c.corner_z);
        e2[0] = 64'(c.prev_x) - 64'(c.corner_x);
        e2[1] = 64'(c.prev_y) - 64'(c.corner_y);
        e2[2] = 64'(c.prev_z) - 64'(c.corner_z);
        if (edge_is_short(e1[0], e1[1], e1[2], tol) || edge_is_short(e2[0], e2[1], e2[2], tol))
        begin
            r.status = tuv_pkg::ST_SHORT_EDGE;
            return r;
        end
        u0  = 64'($signed(c.corner_uv[63:32]));
        v0  = 64'($signed(c.corner_uv[31:0]));
        du1 = 64'($signed(c.next_uv[63:32])) - u0;
        dv1 = 64'($signed(c.next_uv[31:0])) - v0;
        du2 = 64'($signed(c.prev_uv[63:32])) - u0;
        dv2 = 64'($signed(c.prev_uv[31:0])) - v0;
        if (delta_is_small(dv1, tol))
        begin
            if (delta_is_small(du1, tol))
            begin
                r.status = tuv_pkg::ST_NO_UV;
                return r;
            end
            r.tangent_x = scaled_quotient(128'(e1[0]), 128'(du1), sat);
            r.tangent_y = scaled_quotient(128'(e1[1]), 128'(du1), sat);
            r.tangent_z = scaled_quotient(128'(e1[2]), 128'(du1), sat);
        end
        else
        begin
            det    = 128'(dv1) * 128'(du2) - 128'(dv2) * 128'(du1);
            absdet = (det < 0) ? -det : det;
            if (det == 0 || absdet < (128'(tol) << tuv_pkg::FRAC_BITS))
            begin
                r.status = tuv_pkg::ST_DET_ZERO;
                return r;
            end
            num = 128'(dv1) * 128'(e2[0]) - 128'(dv2) * 128'(e1[0]);
            r.tangent_x = scaled_quotient(num, det, sat);
            num = 128'(dv1) * 128'(e2[1]) - 128'(dv2) * 128'(e1[1]);
            r.tangent_y = scaled_quotient(num, det, sat);
            num = 128'(dv1) * 128'(e2[2]) - 128'(dv2) * 128'(e1[2]);
            r.tangent_z = scaled_quotient(num, det, sat);
        end
        r.status    = tuv_pkg::ST_OK;
        r.saturated = sat;
        return r;
    endfunction

    // send one corner, idling at random before it; valid stays up until the next call
    task automatic send_corner(input tuv_pkg::in_item_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        tangent_queue.push_back(predict_tangent(c, tol_shadow));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    // wait for drain, then write the tolerance
    task automatic write_tolerance(input logic [tuv_pkg::TW-1:0] tol);
        in_valid <= 1'b0;
        while (tangent_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= tol;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tol_shadow = tol;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(input int spread);
        case (spread)
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return 32'($signed($urandom_range(20000)) - 10000);
        endcase
    endfunction

    function automatic tuv_pkg::in_item_t rand_corner();
        tuv_pkg::in_item_t c;
        int       sp;
        logic [31:0] u0, v0;
        sp = $urandom_range(9) == 0 ? 0 : ($urandom_range(1) + 1);
        c.corner_x = rand_coord(sp);
        c.corner_y = rand_coord(sp);
        c.corner_z = rand_coord(sp);
        c.next_x   = c.corner_x + rand_coord(sp);
        c.next_y   = c.corner_y + rand_coord(sp);
        c.next_z   = c.corner_z + rand_coord(sp);
        c.prev_x   = c.corner_x + rand_coord(sp);
        c.prev_y   = c.corner_y + rand_coord(sp);
        c.prev_z   = c.corner_z + rand_coord(sp);
        u0 = rand_coord(sp);
        v0 = rand_coord(sp);
        c.corner_uv = {u0, v0};
        c.next_uv   = {u0 + rand_coord(sp), v0 + rand_coord(sp)};
        c.prev_uv   = {u0 + rand_coord(sp), v0 + rand_coord(sp)};
        // occasional degenerate shapes
        case ($urandom_range(15))
            0: {c.next_x, c.next_y, c.next_z} = {c.corner_x, c.corner_y, c.corner_z};
            1: c.next_uv[31:0] = v0 + 32'($urandom_range(2));
            2: c.next_uv = c.corner_uv;
            3: c.prev_uv = c.next_uv;
            4: c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom};
            default: ;
        endcase
        return c;
    endfunction

    function automatic tuv_pkg::in_item_t make_corner(input logic [31:0] nx,
                                                      input logic [31:0] py,
                                                      input logic [31:0] du1,
                                                      input logic [31:0] dv1,
                                                      input logic [31:0] du2,
                                                      input logic [31:0] dv2);
        tuv_pkg::in_item_t c;
        c = '0;
        c.next_x  = nx;
        c.prev_y  = py;
        c.next_uv = {du1, dv1};
        c.prev_uv = {du2, dv2};
        return c;
    endfunction

    task automatic test_directed();
        tuv_pkg::in_item_t c;
        send_corner(make_corner(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0,
                                32'h0001_0000));
        send_corner('0);
        send_corner(make_corner(32'h0001_0000, 0, 32'h0001_0000, 0, 0, 32'h0001_0000));
        send_corner(make_corner(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0));
        send_corner(make_corner(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                32'h0002_0000, 32'h0002_0000));
        send_corner(make_corner(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0002, 0, 0,
                                32'h0001_0000));
        send_corner(make_corner(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 0, 0,
                                32'h0001_0000));
        send_corner(make_corner(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                                32'h0001_0000, 32'h0003_0000));
        send_corner(make_corner(32'h0003_0000, 32'h0005_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h8000_0000));
        c = '1;
        send_corner(c);
        c = {{9{32'h8000_0000}}, {3{64'h7FFF_FFFF_8000_0000}}};
        send_corner(c);
        c = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, {6{32'h8000_0000}},
             64'h0, 64'h8000_0000_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000};
        send_corner(c);
        c = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, {6{32'h7FFF_FFFF}},
             64'h0, 64'h0000_0001_0000_0003, 64'h0000_0005_0000_0002};
        send_corner(c);
    endtask

    task automatic test_random(input int count);
        repeat (count)
            send_corner(rand_corner());
    endtask

    // receiver holds off long while the sender keeps pushing
    task automatic test_backpressure();
        hold_cycles = 150;
        repeat (120)
            send_corner(rand_corner());
    endtask

    // receiver: random stall, long hold when requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (tangent_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", out_data);
            end
            else
            begin
                tuv_pkg::out_item_t want;
                want = tangent_queue.pop_front();
                checked_count++;
                if (out_data.tangent_x !== want.tangent_x ||
                    out_data.tangent_y !== want.tangent_y ||
                    out_data.tangent_z !== want.tangent_z ||
                    out_data.status !== want.status ||
                    out_data.saturated !== want.saturated)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("tangent mismatch: expected %h %h %h st %0d sat %0d",
                                 want.tangent_x, want.tangent_y, want.tangent_z,
                                 want.status, want.saturated);
                        $display("                  got      %h %h %h st %0d sat %0d",
                                 out_data.tangent_x, out_data.tangent_y, out_data.tangent_z,
                                 out_data.status, out_data.saturated);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        tol_shadow     = 16'd1;
        mismatch_count = 0;
        checked_count  = 0;
        sent_count     = 0;
        hold_cycles    = 0;
        send_idle_pct  = 16;
        recv_idle_pct  = 53;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        write_tolerance(16'd0);
        test_directed();
        test_random(150);
        write_tolerance(16'hFFFF);
        test_directed();
        test_random(100);
        send_idle_pct = 53;
        recv_idle_pct = 16;
        write_tolerance(16'd300);
        test_random(200);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_tolerance(16'd1);
        test_random(200);

        in_valid <= 1'b0;
        while (tangent_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        $display("sent %0d corners, checked %0d tangents over tolerances 0, 1, 300, 65535",
                 sent_count, checked_count);
        $display("covered degenerate edges, flat uv, zero det, saturation and long output hold");
        if (mismatch_count == 0 && tangent_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- triangle_uv_tangent.f -----
sv/tuv_pkg.sv
sv/tuv_front.sv
sv/tuv_div.sv
sv/triangle_uv_tangent.sv
sv/tuv_checker.sv
verif/tb_triangle_uv_tangent.sv
